@@ sv/rect_blit_row_generator_top_assert.svh @@
// Assertion macros for the rect blit row generator.
// Used by rect_blit_row_generator_top.sv; expects clk and rst_n in scope.
`ifndef RECT_BLIT_ROW_GENERATOR_TOP_ASSERT_SVH
`define RECT_BLIT_ROW_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define RBRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define RBRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rbrg_pkg.sv @@
// Package for the rect blit row generator: widths, opcodes, register indexes
// and the word, configuration and clip structs. No dependencies.
`timescale 1ns / 1ps

package rbrg_pkg;

  localparam int DIM_W       = 11;
  localparam int POS_W       = 10;
  localparam int ADDR_W      = 20;
  localparam int GLYPH_W     = 8;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  // largest buffer dimension; DIM_W is sized for it
  localparam int MAX_DIM     = 1024;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // opcodes; the fourth code is ignored
  localparam op_t OP_COPY = 2'd0;
  localparam op_t OP_FILL = 2'd1;
  localparam op_t OP_STEP = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t CFG_SRC_ROWS = 2'd0;
  localparam cfg_idx_t CFG_SRC_COLS = 2'd1;
  localparam cfg_idx_t CFG_DST_ROWS = 2'd2;
  localparam cfg_idx_t CFG_DST_COLS = 2'd3;

  typedef struct packed {
    op_t                opcode;
    logic [POS_W-1:0]   src_row;
    logic [POS_W-1:0]   src_col;
    logic [POS_W-1:0]   dst_row;
    logic [POS_W-1:0]   dst_col;
    logic [DIM_W-1:0]   rect_rows;
    logic [DIM_W-1:0]   rect_cols;
    logic [GLYPH_W-1:0] fill_value;
  } in_item_t;

  typedef struct packed {
    logic               is_fill;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [DIM_W-1:0]   row_length;
    logic [GLYPH_W-1:0] glyph;
    logic               last_row;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] src_rows;
    logic [DIM_W-1:0] src_cols;
    logic [DIM_W-1:0] dst_rows;
    logic [DIM_W-1:0] dst_cols;
  } geom_t;

  // pre-clipped request, held in the input register
  typedef struct packed {
    logic               start;     // copy or fill request
    logic               step;      // step to next row
    logic               accept;    // start that survives clipping
    logic               fill;
    logic               going_up;
    logic [DIM_W-1:0]   src_row;   // first emitted source row
    logic [POS_W-1:0]   src_col;
    logic [DIM_W-1:0]   dst_row;   // first emitted destination row
    logic [POS_W-1:0]   dst_col;
    logic [DIM_W-1:0]   rows;      // clipped height
    logic [DIM_W-1:0]   len;       // clipped width
    logic [GLYPH_W-1:0] glyph;
  } clip_t;

endpackage

@@ sv/rbrg_clip.sv @@
// Request clipper: decodes the opcode and clips a copy or fill rectangle
// against the buffer geometry. Pure combinational. Depends on rbrg_pkg.
`timescale 1ns / 1ps

module rbrg_clip
  import rbrg_pkg::*;
(
  input  in_item_t in_data,
  input  geom_t    geom,
  output clip_t    clip
);

  logic [DIM_W-1:0] sr, sc, dr, dc;
  logic [DIM_W-1:0] src_rows_left, dst_rows_left;
  logic [DIM_W-1:0] src_cols_left, dst_cols_left;
  logic [DIM_W-1:0] ny_copy, ny_fill, len_copy, len_fill;
  logic             copy_out, fill_out;

  assign sr = {1'b0, in_data.src_row};
  assign sc = {1'b0, in_data.src_col};
  assign dr = {1'b0, in_data.dst_row};
  assign dc = {1'b0, in_data.dst_col};

  // room left in each buffer from the start corner
  assign src_rows_left = geom.src_rows - sr;
  assign dst_rows_left = geom.dst_rows - dr;
  assign src_cols_left = geom.src_cols - sc;
  assign dst_cols_left = geom.dst_cols - dc;

  assign fill_out = (dr >= geom.dst_rows) || (dc >= geom.dst_cols);
  assign copy_out = fill_out || (sr >= geom.src_rows) || (sc >= geom.src_cols);

  // clipped extents
  always_comb begin
    ny_fill  = (in_data.rect_rows < dst_rows_left) ? in_data.rect_rows : dst_rows_left;
    ny_copy  = (ny_fill < src_rows_left) ? ny_fill : src_rows_left;
    len_fill = (in_data.rect_cols < dst_cols_left) ? in_data.rect_cols : dst_cols_left;
    len_copy = (len_fill < src_cols_left) ? len_fill : src_cols_left;
  end

  // decode
  always_comb begin
    clip          = '0;
    clip.src_col  = in_data.src_col;
    clip.dst_col  = in_data.dst_col;
    clip.src_row  = sr;
    clip.dst_row  = dr;
    case (in_data.opcode)
      OP_COPY: begin
        clip.start    = 1'b1;
        clip.accept   = !copy_out && (ny_copy != '0);
        clip.rows     = ny_copy;
        clip.len      = len_copy;
        clip.going_up = (sr < dr);
        // bottom-up copies begin on the last row
        if (sr < dr) begin
          clip.src_row = sr + (ny_copy - DIM_W'(1));
          clip.dst_row = dr + (ny_copy - DIM_W'(1));
        end
      end
      OP_FILL: begin
        clip.start   = 1'b1;
        clip.accept  = !fill_out && (ny_fill != '0);
        clip.fill    = 1'b1;
        clip.rows    = ny_fill;
        clip.len     = len_fill;
        clip.glyph   = in_data.fill_value;
        clip.src_row = '0;
        clip.src_col = '0;
      end
      OP_STEP: begin
        clip.step = 1'b1;
      end
      default: begin
        // ignored opcode: no start, no step
      end
    endcase
  end

endmodule

@@ sv/rect_blit_row_generator_top.sv @@
// Rect blit row generator, top level. Depends on rbrg_pkg, rbrg_clip and
// rect_blit_row_generator_top_assert.svh.
// Input channel (in_valid/in_ready/in_data) takes copy, fill and step words;
// output channel (out_valid/out_ready/out_data) gives one row command word
// per start that survives clipping and per step while rows remain.
// cfg_wr_en/cfg_index/cfg_wdata write the buffer geometry; values above
// MAX_DIM are saturated. Write it only while no request is in flight.
// Pipeline: input word is clipped and registered on acceptance; when the
// output register is free, start addresses are computed (one 11x11 multiply
// per buffer) or the row addresses are stepped by the stride, and the
// output register is loaded.
// Throughput: one word per cycle while out_ready is high; the input register lets a new word enter
// while a finished row command waits to be taken.
// When out_ready is low the output holds and the input register fills, then
// in_ready drops. Reset clears the geometry, the pending row count and both
// valid flags, leaving the block idle.
`timescale 1ns / 1ps
`include "rect_blit_row_generator_top_assert.svh"

module rect_blit_row_generator_top
  import rbrg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata
);

  geom_t             geom_r;
  logic [DIM_W-1:0]  cfg_sat;
  clip_t             clip_c, clip_r;
  logic              in_vld_r, out_vld_r, proc_en, busy, reject_c;
  out_item_t         out_r, out_nxt;
  logic [DIM_W-1:0]  rem_r, rem_nxt, len_r, len_nxt;
  logic [ADDR_W-1:0] cur_src_r, cur_src_nxt, cur_dst_r, cur_dst_nxt;
  logic [ADDR_W-1:0] step_src, step_dst, start_src, start_dst;
  logic [2*DIM_W-1:0] src_prod, dst_prod;
  logic              fill_r, fill_nxt, up_r, up_nxt, emit;
  logic [GLYPH_W-1:0] glyph_r, glyph_nxt;

  // configuration writes with saturation
  assign cfg_sat = (32'(cfg_wdata) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SRC_ROWS: geom_r.src_rows <= cfg_sat;
        CFG_SRC_COLS: geom_r.src_cols <= cfg_sat;
        CFG_DST_ROWS: geom_r.dst_rows <= cfg_sat;
        CFG_DST_COLS: geom_r.dst_cols <= cfg_sat;
        default: ;
      endcase
    end
  end

  // clip on the way in
  rbrg_clip u_clip (
    .in_data (in_data),
    .geom    (geom_r),
    .clip    (clip_c)
  );

  // handshake
  assign proc_en   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || proc_en;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign busy      = (rem_r != '0);
  assign reject_c  = proc_en && clip_r.start && !clip_r.accept;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (proc_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      clip_r <= clip_c;
    end
  end

  // start addresses: row * stride + column
  assign src_prod  = (2*DIM_W)'(clip_r.src_row) * (2*DIM_W)'(geom_r.src_cols);
  assign dst_prod  = (2*DIM_W)'(clip_r.dst_row) * (2*DIM_W)'(geom_r.dst_cols);
  assign start_src = ADDR_W'(src_prod + (2*DIM_W)'(clip_r.src_col));
  assign start_dst = ADDR_W'(dst_prod + (2*DIM_W)'(clip_r.dst_col));

  // next row addresses from the previous one
  assign step_src = up_r ? (cur_src_r - ADDR_W'(geom_r.src_cols))
                         : (cur_src_r + ADDR_W'(geom_r.src_cols));
  assign step_dst = up_r ? (cur_dst_r - ADDR_W'(geom_r.dst_cols))
                         : (cur_dst_r + ADDR_W'(geom_r.dst_cols));

  // row sequencing
  always_comb begin
    rem_nxt     = rem_r;
    cur_src_nxt = cur_src_r;
    cur_dst_nxt = cur_dst_r;
    fill_nxt    = fill_r;
    up_nxt      = up_r;
    len_nxt     = len_r;
    glyph_nxt   = glyph_r;
    out_nxt     = out_r;
    emit        = 1'b0;
    if (proc_en) begin
      if (clip_r.step) begin
        if (busy) begin
          emit                = 1'b1;
          rem_nxt             = rem_r - DIM_W'(1);
          cur_src_nxt         = step_src;
          cur_dst_nxt         = step_dst;
          out_nxt.is_fill     = fill_r;
          out_nxt.src_addr    = fill_r ? '0 : step_src;
          out_nxt.dst_addr    = step_dst;
          out_nxt.row_length  = len_r;
          out_nxt.glyph       = fill_r ? glyph_r : '0;
          out_nxt.last_row    = (rem_r == DIM_W'(1));
        end
      end else if (clip_r.start) begin
        // any start drops pending rows
        rem_nxt = '0;
        if (clip_r.accept) begin
          emit                = 1'b1;
          rem_nxt             = clip_r.rows - DIM_W'(1);
          cur_src_nxt         = start_src;
          cur_dst_nxt         = start_dst;
          fill_nxt            = clip_r.fill;
          up_nxt              = clip_r.going_up;
          len_nxt             = clip_r.len;
          glyph_nxt           = clip_r.glyph;
          out_nxt.is_fill     = clip_r.fill;
          out_nxt.src_addr    = clip_r.fill ? '0 : start_src;
          out_nxt.dst_addr    = start_dst;
          out_nxt.row_length  = clip_r.len;
          out_nxt.glyph       = clip_r.glyph;
          out_nxt.last_row    = (clip_r.rows == DIM_W'(1));
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      if (proc_en) begin
        out_vld_r <= emit;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // row payload state
  always_ff @(posedge clk) begin
    cur_src_r <= cur_src_nxt;
    cur_dst_r <= cur_dst_nxt;
    fill_r    <= fill_nxt;
    up_r      <= up_nxt;
    len_r     <= len_nxt;
    glyph_r   <= glyph_nxt;
    out_r     <= out_nxt;
  end

  // checks
  `RBRG_ASSERT_NOW(a_last_pending, out_valid, out_data.last_row == !busy, "last_row vs rows left")
  `RBRG_ASSERT_NEXT(a_idle_step, proc_en && clip_r.step && !busy, !out_valid, "idle step emitted")
  `RBRG_ASSERT_NEXT(a_reject, reject_c, !busy && !out_valid, "rejected start left rows")

endmodule
